// ===== rtl/roit_pkg.sv =====
// ----------------------------------------------------------------------------
// roit_pkg: shared types and constants for the ranged object interval table
// Holds the table geometry, operation codes, controller states and the
// command/status structs passed between controller and datapath.
// ----------------------------------------------------------------------------
package roit_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int POS_W = 32;
  localparam int ID_W  = 16;

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_REPLACE = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_LOOKUP  = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_WALK   = 5'b00010,
    ST_SHIFT  = 5'b00100,
    ST_INSERT = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;         // capture a new item
    logic walk_step;    // examine one stored entry
    logic finish_walk;  // close the walk, commit count when no insert follows
    logic shift_step;   // move one entry up by one slot
    logic insert;       // write the new range and commit count
    logic emit_step;    // load one result into the output register
  } cmd_t;

  typedef struct packed {
    logic skip_walk;    // zero-length add at the input
    logic walk_done;
    logic need_insert;
    logic shift_done;
    logic out_free;
    logic emit_last;
  } status_t;

endpackage

// ===== rtl/roit_ctrl.sv =====
// ----------------------------------------------------------------------------
// roit_ctrl: operation sequencer; steps each item through walk (skipped for
// a zero-length add), optional shift and insert, then result emit.
// ----------------------------------------------------------------------------
module roit_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  roit_pkg::status_t  status,
  output roit_pkg::cmd_t     cmd
);

  roit_pkg::state_t state, state_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) state <= roit_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      roit_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.skip_walk ? roit_pkg::ST_EMIT : roit_pkg::ST_WALK;
        end
      end
      roit_pkg::ST_WALK: begin
        if (status.walk_done) begin
          cmd.finish_walk = 1'b1;
          state_next = status.need_insert ? roit_pkg::ST_SHIFT : roit_pkg::ST_EMIT;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      roit_pkg::ST_SHIFT: begin
        if (status.shift_done) state_next = roit_pkg::ST_INSERT;
        else                   cmd.shift_step = 1'b1;
      end
      roit_pkg::ST_INSERT: begin
        cmd.insert = 1'b1;
        state_next = roit_pkg::ST_EMIT;
      end
      roit_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_step = 1'b1;
          if (status.emit_last) state_next = roit_pkg::ST_IDLE;
        end
      end
      default: state_next = roit_pkg::ST_IDLE;
    endcase
  end

  assign in_stall = (state != roit_pkg::ST_IDLE);

endmodule

// ===== rtl/roit_dp.sv =====
// ----------------------------------------------------------------------------
// roit_dp: table storage, walk/compaction datapath and output register
// Holds the entries, the eviction buffer and the result register.
// ----------------------------------------------------------------------------
module roit_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  roit_pkg::cmd_t                cmd,
  output roit_pkg::status_t             status,
  input  logic [1:0]                    kind,
  input  logic [roit_pkg::POS_W-1:0]    range_start,
  input  logic [roit_pkg::POS_W-1:0]    range_length,
  input  logic [roit_pkg::ID_W-1:0]     object_id,
  input  logic [roit_pkg::POS_W-1:0]    repl_length,
  input  logic [roit_pkg::POS_W-1:0]    lookup_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [roit_pkg::ID_W-1:0]     result_id,
  output logic                          has_object,
  output logic                          is_last,
  output logic                          table_full
);

  localparam int D  = roit_pkg::TABLE_DEPTH;
  localparam int IW = roit_pkg::IDX_W;
  localparam int CW = roit_pkg::CNT_W;
  localparam int PW = roit_pkg::POS_W;
  localparam int DW = roit_pkg::ID_W;

  // Table and eviction buffer
  logic [PW-1:0] ent_start [D];
  logic [PW-1:0] ent_len   [D];
  logic [DW-1:0] ent_id    [D];
  logic [DW-1:0] ev_buf    [D];

  // Captured item
  roit_pkg::kind_t op_kind;
  logic [PW-1:0]   op_start, op_len, op_nlen, op_idx;
  logic [DW-1:0]   op_id;

  // Walk control
  logic [CW-1:0] count, rd_i, wr_w, pos, jdx, n_ev, e_idx;
  logic          stopped, found, full_flag;

  // Read port
  logic [CW-1:0] jm1;
  logic [IW-1:0] rd_addr;
  logic [PW-1:0] r_start, r_len;
  logic [DW-1:0] r_id;
  logic [PW:0]   ent_end, op_end;
  logic          ovl, contains, past_end;

  assign jm1     = jdx - CW'(1);
  assign rd_addr = cmd.shift_step ? jm1[IW-1:0] : rd_i[IW-1:0];
  assign r_start = ent_start[rd_addr];
  assign r_len   = ent_len[rd_addr];
  assign r_id    = ent_id[rd_addr];

  assign ent_end  = {1'b0, r_start} + {1'b0, r_len};
  assign op_end   = {1'b0, op_start} + {1'b0, op_len};
  assign ovl      = ({1'b0, r_start} < op_end) && ({1'b0, op_start} < ent_end);
  assign contains = (op_idx >= r_start) && ({1'b0, op_idx} < ent_end);
  assign past_end = ({1'b0, r_start} >= op_end);

  // Classify the entry under the walk
  logic evict, keep, stop_now, hit;
  logic [PW-1:0] keep_start;
  always_comb begin
    evict    = 1'b0;
    keep     = 1'b0;
    stop_now = 1'b0;
    hit      = 1'b0;
    keep_start = r_start;
    case (op_kind)
      roit_pkg::KIND_ADD: begin
        evict    = !stopped && ovl;
        keep     = !evict;
        stop_now = !stopped && !ovl && past_end;
      end
      roit_pkg::KIND_REPLACE: begin
        evict = ovl;
        keep  = !ovl;
        if (past_end) keep_start = r_start - op_len + op_nlen;
      end
      roit_pkg::KIND_CLEAR: evict = 1'b1;
      default:              hit = !found && contains;
    endcase
  end

  logic [CW-1:0] ins_pos, commit_cnt;
  assign ins_pos = stopped ? pos : wr_w;
  always_comb begin
    case (op_kind)
      roit_pkg::KIND_CLEAR:  commit_cnt = '0;
      roit_pkg::KIND_LOOKUP: commit_cnt = count;
      default:               commit_cnt = wr_w;
    endcase
  end

  assign status.skip_walk   = (roit_pkg::kind_t'(kind) == roit_pkg::KIND_ADD) &&
                              (range_length == '0);
  assign status.walk_done   = (rd_i >= count);
  assign status.need_insert = (op_kind == roit_pkg::KIND_ADD) && (wr_w < CW'(D));
  assign status.shift_done  = (jdx == ins_pos);
  assign status.out_free    = !out_valid || !out_stall;
  assign status.emit_last   = (n_ev == '0) || (e_idx == n_ev - CW'(1));

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish_walk && !status.need_insert) count <= commit_cnt;
      if (cmd.insert) count <= wr_w + CW'(1);
      // Hold while stalled, drop once taken
      if (cmd.emit_step)     out_valid <= 1'b1;
      else if (!out_stall)   out_valid <= 1'b0;
    end
  end

  // Capture the item and sequence the walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_kind   <= roit_pkg::kind_t'(kind);
      op_start  <= range_start;
      op_len    <= range_length;
      op_id     <= object_id;
      op_nlen   <= repl_length;
      op_idx    <= lookup_index;
      rd_i      <= '0;
      wr_w      <= '0;
      pos       <= '0;
      n_ev      <= '0;
      e_idx     <= '0;
      stopped   <= 1'b0;
      found     <= 1'b0;
      full_flag <= 1'b0;
    end
    if (cmd.walk_step) begin
      rd_i <= rd_i + CW'(1);
      if (evict) begin
        ev_buf[n_ev[IW-1:0]] <= r_id;
        n_ev <= n_ev + CW'(1);
      end
      if (hit) begin
        ev_buf[0] <= r_id;
        n_ev      <= CW'(1);
        found     <= 1'b1;
      end
      if (stop_now) begin
        stopped <= 1'b1;
        pos     <= wr_w;
      end
      if (keep) begin
        ent_start[wr_w[IW-1:0]] <= keep_start;
        ent_len[wr_w[IW-1:0]]   <= r_len;
        ent_id[wr_w[IW-1:0]]    <= r_id;
        wr_w <= wr_w + CW'(1);
      end
    end
    if (cmd.finish_walk) begin
      jdx       <= wr_w;
      full_flag <= (op_kind == roit_pkg::KIND_ADD) && (wr_w >= CW'(D));
    end
    // Move one entry up toward the insert point
    if (cmd.shift_step) begin
      ent_start[jdx[IW-1:0]] <= r_start;
      ent_len[jdx[IW-1:0]]   <= r_len;
      ent_id[jdx[IW-1:0]]    <= r_id;
      jdx <= jm1;
    end
    if (cmd.insert) begin
      ent_start[ins_pos[IW-1:0]] <= op_start;
      ent_len[ins_pos[IW-1:0]]   <= op_len;
      ent_id[ins_pos[IW-1:0]]    <= op_id;
    end
    // Load one result
    if (cmd.emit_step) begin
      table_full <= full_flag;
      is_last    <= status.emit_last;
      if (n_ev == '0) begin
        result_id  <= '0;
        has_object <= 1'b0;
      end else begin
        result_id  <= ev_buf[e_idx[IW-1:0]];
        has_object <= 1'b1;
      end
      e_idx <= e_idx + CW'(1);
    end
  end

endmodule

// ===== rtl/ranged_object_interval_table_top.sv =====
// ----------------------------------------------------------------------------
// ranged_object_interval_table_top: ordered range table with eviction report
//
//   channel | direction | handshake          | payload
//   input   | in        | in_valid/in_stall  | kind, range_start, range_length,
//           |           |                    | object_id, repl_length, lookup_index
//   output  | out       | out_valid/out_stall| result_id, has_object, is_last,
//           |           |                    | table_full
//
// Each item is accepted, walked over the stored entries (a zero-length add
// skips the walk) and then emits its results one by one; an add that inserts
// first shifts the entries above the insert point up and writes the new range.
// The walk examines one stored entry per cycle through a single read port.
// Reset empties the table by zeroing the entry count; no clearing pass.
// Output stalls hold the result register and pause the emit phase only.
// ----------------------------------------------------------------------------
module ranged_object_interval_table_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 kind,
  input  logic [roit_pkg::POS_W-1:0] range_start,
  input  logic [roit_pkg::POS_W-1:0] range_length,
  input  logic [roit_pkg::ID_W-1:0]  object_id,
  input  logic [roit_pkg::POS_W-1:0] repl_length,
  input  logic [roit_pkg::POS_W-1:0] lookup_index,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [roit_pkg::ID_W-1:0]  result_id,
  output logic                       has_object,
  output logic                       is_last,
  output logic                       table_full
);

  roit_pkg::cmd_t    cmd;
  roit_pkg::status_t status;

  roit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  roit_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .kind         (kind),
    .range_start  (range_start),
    .range_length (range_length),
    .object_id    (object_id),
    .repl_length  (repl_length),
    .lookup_index (lookup_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_id    (result_id),
    .has_object   (has_object),
    .is_last      (is_last),
    .table_full   (table_full)
  );

endmodule

// ===== rtl/roit_checker.sv =====
// ----------------------------------------------------------------------------
// roit_checker: port-level checks for the range table
// Watches result framing and output register behavior over time.
// ----------------------------------------------------------------------------
module roit_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [roit_pkg::ID_W-1:0]  result_id,
  input logic                       has_object,
  input logic                       is_last
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_id))
    else $error("stalled result changed");

  // Empty result carries id zero
  a_empty_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_object |-> result_id == '0)
    else $error("empty result with nonzero id");

  // Empty result closes its run
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_object |-> is_last)
    else $error("empty result not marked last");

  // A run continues without gaps
  a_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !is_last |=> out_valid)
    else $error("gap inside a result run");

  // Input side is busy while a run is open
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_last |-> in_stall)
    else $error("item accepted during a result run");

endmodule

bind ranged_object_interval_table_top roit_checker u_roit_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .result_id  (result_id),
  .has_object (has_object),
  .is_last    (is_last)
);
